[design/rap_pkg.sv]
// Package for the pivot rotator: word types, angle scale factors and the CORDIC arctangent table.
package rap_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pivot_x;
        logic signed [31:0] pivot_y;
        logic signed [31:0] angle;
        logic               angle_in_degrees;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic               saturated;
    } out_word_t;

    // Point data that rides alongside the angle through the sine/cosine pipeline.
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } side_t;

    localparam logic REG_ZERO_SNAP = 1'b0;
    localparam logic [15:0] ZERO_SNAP_RESET = 16'd7;

    localparam logic [33:0] RAD_TO_PHASE = 34'd10937044409;
    localparam logic [33:0] DEG_TO_PHASE = 34'd190887435;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    localparam int ATAN_DEPTH = 32;
    localparam logic [29:0] ATAN_PHASE [ATAN_DEPTH] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331, 30'd21354465, 30'd10679838, 30'd5340245,
        30'd2670163, 30'd1335087, 30'd667544, 30'd333772,
        30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304,
        30'd652, 30'd326, 30'd163, 30'd81,
        30'd41, 30'd20, 30'd10, 30'd5,
        30'd3, 30'd1, 30'd1, 30'd0
    };

endpackage

[design/rap_phase.sv]
// Angle to phase conversion in three stages: split multiply, rounding sum, quadrant split.
module rap_phase
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 vld,
    input  rap_pkg::in_word_t    item,
    output logic                 z_vld,
    output logic signed [31:0]   z,
    output logic [1:0]           quad,
    output rap_pkg::side_t       side
);

    logic [33:0]         k;
    logic signed [49:0]  p_lo_next;
    logic signed [49:0]  p_hi_next;
    rap_pkg::side_t      side_next;

    logic signed [49:0]  p_lo_reg;
    logic signed [49:0]  p_hi_reg;
    rap_pkg::side_t      side1_reg;
    logic                vld1_reg;

    logic [55:0]         full_next;
    logic [31:0]         phase_reg;
    rap_pkg::side_t      side2_reg;
    logic                vld2_reg;

    logic [31:0]         qsum;
    logic [1:0]          quad_next;
    logic [31:0]         res_next;
    logic signed [31:0]  z_reg;
    logic [1:0]          quad_reg;
    rap_pkg::side_t      side3_reg;
    logic                vld3_reg;

    always_comb
    begin
        k = item.angle_in_degrees ? rap_pkg::DEG_TO_PHASE : rap_pkg::RAD_TO_PHASE;
        p_lo_next = $signed(item.angle) * $signed({1'b0, k[16:0]});
        p_hi_next = $signed(item.angle) * $signed({1'b0, k[33:17]});
        side_next.dx = $signed({item.pos_x[31], item.pos_x})
                       - $signed({item.pivot_x[31], item.pivot_x});
        side_next.dy = $signed({item.pos_y[31], item.pos_y})
                       - $signed({item.pivot_y[31], item.pivot_y});
        side_next.cx = item.pivot_x;
        side_next.cy = item.pivot_y;
    end

    // The phase is the product modulo 2^56, rounded and taken from bits 55..24.
    assign full_next = {p_hi_reg[38:0], 17'b0} + {{6{p_lo_reg[49]}}, p_lo_reg}
                       + 56'h0000_0000_80_0000;

    always_comb
    begin
        qsum = phase_reg + 32'h2000_0000;
        quad_next = qsum[31:30];
        res_next = phase_reg - {quad_next, 30'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_lo_reg  <= p_lo_next;
        p_hi_reg  <= p_hi_next;
        side1_reg <= side_next;
        phase_reg <= full_next[55:24];
        side2_reg <= side1_reg;
        z_reg     <= $signed(res_next);
        quad_reg  <= quad_next;
        side3_reg <= side2_reg;
    end

    assign z_vld = vld3_reg;
    assign z     = z_reg;
    assign quad  = quad_reg;
    assign side  = side3_reg;

endmodule

[design/rap_cordic.sv]
// Pipelined CORDIC, one iteration per stage, followed by clamping and quadrant restore.
module rap_cordic
#(
    parameter int CORDIC_STEPS = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 z_vld,
    input  logic signed [31:0]   z,
    input  logic [1:0]           quad,
    input  rap_pkg::side_t       side,
    output logic                 cs_vld,
    output logic signed [31:0]   cos_val,
    output logic signed [31:0]   sin_val,
    output rap_pkg::side_t       cs_side
);

    logic signed [33:0]  x_reg    [CORDIC_STEPS];
    logic signed [33:0]  y_reg    [CORDIC_STEPS];
    logic signed [33:0]  z_reg    [CORDIC_STEPS];
    logic [1:0]          quad_reg [CORDIC_STEPS];
    rap_pkg::side_t      side_reg [CORDIC_STEPS];
    logic [CORDIC_STEPS-1:0] vld_reg;

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++)
        begin : g_iter
            logic signed [33:0] xi;
            logic signed [33:0] yi;
            logic signed [33:0] zi;
            logic [1:0]         qi;
            rap_pkg::side_t     si;
            logic               vi;
            logic signed [33:0] x_next;
            logic signed [33:0] y_next;
            logic signed [33:0] z_next;
            logic signed [33:0] atan_step;

            if (i == 0)
            begin : g_first
                assign xi = rap_pkg::CORDIC_GAIN;
                assign yi = '0;
                assign zi = {{2{z[31]}}, z};
                assign qi = quad;
                assign si = side;
                assign vi = z_vld;
            end
            else
            begin : g_rest
                assign xi = x_reg[i-1];
                assign yi = y_reg[i-1];
                assign zi = z_reg[i-1];
                assign qi = quad_reg[i-1];
                assign si = side_reg[i-1];
                assign vi = vld_reg[i-1];
            end

            assign atan_step = $signed({4'b0, rap_pkg::ATAN_PHASE[i]});

            always_comb
            begin
                if (!zi[33])
                begin
                    x_next = xi - (yi >>> i);
                    y_next = yi + (xi >>> i);
                    z_next = zi - atan_step;
                end
                else
                begin
                    x_next = xi + (yi >>> i);
                    y_next = yi - (xi >>> i);
                    z_next = zi + atan_step;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else
                begin
                    vld_reg[i] <= vi;
                end
            end

            always_ff @(posedge clk)
            begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
                quad_reg[i] <= qi;
                side_reg[i] <= si;
            end
        end
    endgenerate

    logic signed [33:0]  x_last;
    logic signed [33:0]  y_last;
    logic signed [31:0]  xc;
    logic signed [31:0]  yc;
    logic signed [31:0]  cos_next;
    logic signed [31:0]  sin_next;
    logic signed [31:0]  cos_reg;
    logic signed [31:0]  sin_reg;
    rap_pkg::side_t      out_side_reg;
    logic                out_vld_reg;

    assign x_last = x_reg[CORDIC_STEPS-1];
    assign y_last = y_reg[CORDIC_STEPS-1];

    always_comb
    begin
        if (x_last > rap_pkg::ONE_Q30)
        begin
            xc = rap_pkg::ONE_Q30[31:0];
        end
        else if (x_last < -rap_pkg::ONE_Q30)
        begin
            xc = -rap_pkg::ONE_Q30[31:0];
        end
        else
        begin
            xc = x_last[31:0];
        end

        if (y_last > rap_pkg::ONE_Q30)
        begin
            yc = rap_pkg::ONE_Q30[31:0];
        end
        else if (y_last < -rap_pkg::ONE_Q30)
        begin
            yc = -rap_pkg::ONE_Q30[31:0];
        end
        else
        begin
            yc = y_last[31:0];
        end

        case (quad_reg[CORDIC_STEPS-1])
            2'd0:
            begin
                cos_next = xc;
                sin_next = yc;
            end
            2'd1:
            begin
                cos_next = -yc;
                sin_next = xc;
            end
            2'd2:
            begin
                cos_next = -xc;
                sin_next = -yc;
            end
            default:
            begin
                cos_next = yc;
                sin_next = -xc;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= vld_reg[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        cos_reg      <= cos_next;
        sin_reg      <= sin_next;
        out_side_reg <= side_reg[CORDIC_STEPS-1];
    end

    assign cs_vld  = out_vld_reg;
    assign cos_val = cos_reg;
    assign sin_val = sin_reg;
    assign cs_side = out_side_reg;

endmodule

[design/rap_rotate.sv]
// Rotation of the offset vector in four stages: products, sums, rounding with pivot, snap and clip.
module rap_rotate
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cs_vld,
    input  logic signed [31:0]   cos_val,
    input  logic signed [31:0]   sin_val,
    input  rap_pkg::side_t       cs_side,
    input  logic [15:0]          thr,
    output logic                 done,
    output rap_pkg::out_word_t   result
);

    logic signed [64:0]  xc_reg;
    logic signed [64:0]  ys_reg;
    logic signed [64:0]  xs_reg;
    logic signed [64:0]  yc_reg;
    logic signed [31:0]  cx1_reg;
    logic signed [31:0]  cy1_reg;
    logic                vld1_reg;

    logic signed [65:0]  accx_reg;
    logic signed [65:0]  accy_reg;
    logic signed [31:0]  cx2_reg;
    logic signed [31:0]  cy2_reg;
    logic                vld2_reg;

    logic signed [65:0]  rndx;
    logic signed [65:0]  rndy;
    logic signed [36:0]  vx_next;
    logic signed [36:0]  vy_next;
    logic signed [36:0]  vx_reg;
    logic signed [36:0]  vy_reg;
    logic                vld3_reg;

    logic signed [36:0]  thr_s;
    logic signed [31:0]  nx_next;
    logic signed [31:0]  ny_next;
    logic                satx;
    logic                saty;
    rap_pkg::out_word_t  result_reg;
    logic                done_reg;

    always_comb
    begin
        rndx = accx_reg + (66'sd1 <<< 29);
        rndy = accy_reg + (66'sd1 <<< 29);
        vx_next = $signed({rndx[65], rndx[65:30]}) + $signed({{5{cx2_reg[31]}}, cx2_reg});
        vy_next = $signed({rndy[65], rndy[65:30]}) + $signed({{5{cy2_reg[31]}}, cy2_reg});
    end

    always_comb
    begin
        thr_s = $signed({21'b0, thr});
        satx = 1'b0;
        saty = 1'b0;
        if (vx_reg <= thr_s && vx_reg >= -thr_s)
        begin
            nx_next = '0;
        end
        else if (vx_reg > 37'sd2147483647)
        begin
            nx_next = 32'sh7FFF_FFFF;
            satx = 1'b1;
        end
        else if (vx_reg < -37'sd2147483648)
        begin
            nx_next = 32'sh8000_0000;
            satx = 1'b1;
        end
        else
        begin
            nx_next = vx_reg[31:0];
        end

        if (vy_reg <= thr_s && vy_reg >= -thr_s)
        begin
            ny_next = '0;
        end
        else if (vy_reg > 37'sd2147483647)
        begin
            ny_next = 32'sh7FFF_FFFF;
            saty = 1'b1;
        end
        else if (vy_reg < -37'sd2147483648)
        begin
            ny_next = 32'sh8000_0000;
            saty = 1'b1;
        end
        else
        begin
            ny_next = vy_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= cs_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            done_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        xc_reg   <= $signed(cs_side.dx) * cos_val;
        ys_reg   <= $signed(cs_side.dy) * sin_val;
        xs_reg   <= $signed(cs_side.dx) * sin_val;
        yc_reg   <= $signed(cs_side.dy) * cos_val;
        cx1_reg  <= cs_side.cx;
        cy1_reg  <= cs_side.cy;
        accx_reg <= $signed({xc_reg[64], xc_reg}) - $signed({ys_reg[64], ys_reg});
        accy_reg <= $signed({xs_reg[64], xs_reg}) + $signed({yc_reg[64], yc_reg});
        cx2_reg  <= cx1_reg;
        cy2_reg  <= cy1_reg;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        result_reg.new_x     <= nx_next;
        result_reg.new_y     <= ny_next;
        result_reg.saturated <= satx | saty;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[design/rotate_about_pivot_2d.sv]
// Top level of the pivot rotator: configuration register, pipeline hookup and checks.
// The rotator takes one word on every clock cycle at which start is high; busy never rises,
// since the pipeline has no stall path. Each word's result leaves on result with a one-cycle
// done strobe after the pipeline: the angle is turned into a phase, the CORDIC iterations
// plus a clamping register give sine and cosine, and the rotation stages multiply, sum,
// round and snap. Results come out in input order and must be taken when done is high.
// The zero snap threshold should only be written while no word is in flight.
module rotate_about_pivot_2d
#(
    parameter int CORDIC_STEPS = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rap_pkg::in_word_t    item,
    output logic                 done,
    output rap_pkg::out_word_t   result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int LATENCY = CORDIC_STEPS + 8;

    logic [15:0]         thr_reg;
    logic                accept;
    logic                z_vld;
    logic signed [31:0]  z;
    logic [1:0]          quad;
    rap_pkg::side_t      side;
    logic                cs_vld;
    logic signed [31:0]  cos_val;
    logic signed [31:0]  sin_val;
    rap_pkg::side_t      cs_side;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= rap_pkg::ZERO_SNAP_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == rap_pkg::REG_ZERO_SNAP)
        begin
            thr_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == rap_pkg::REG_ZERO_SNAP) ? {16'b0, thr_reg} : 32'b0;

    rap_phase u_phase
    (
        .clk   (clk),
        .rst_n (rst_n),
        .vld   (accept),
        .item  (item),
        .z_vld (z_vld),
        .z     (z),
        .quad  (quad),
        .side  (side)
    );

    rap_cordic
    #(
        .CORDIC_STEPS (CORDIC_STEPS)
    )
    u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .z_vld   (z_vld),
        .z       (z),
        .quad    (quad),
        .side    (side),
        .cs_vld  (cs_vld),
        .cos_val (cos_val),
        .sin_val (sin_val),
        .cs_side (cs_side)
    );

    rap_rotate u_rotate
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cs_vld  (cs_vld),
        .cos_val (cos_val),
        .sin_val (sin_val),
        .cs_side (cs_side),
        .thr     (thr_reg),
        .done    (done),
        .result  (result)
    );

    // Every accepted word comes out after the fixed pipeline latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted word did not produce a result on time");

    // A result never appears without a matching accepted word.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without an accepted word");

    // A clipped result holds at least one coordinate at an end of the range.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.saturated) |->
            (result.new_x == 32'sh7FFF_FFFF || result.new_x == 32'sh8000_0000
             || result.new_y == 32'sh7FFF_FFFF || result.new_y == 32'sh8000_0000))
        else $error("saturated flag without a clipped coordinate");

endmodule

[sim/rotation_check_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the pivot rotator: a fixed-point rotation predictor and its result checks.
package rotation_check_pkg;

    localparam int CORDIC_STEPS = 24;

    localparam longint unsigned RADIAN_SCALE = 64'd10937044409;
    localparam longint unsigned DEGREE_SCALE = 64'd190887435;
    localparam longint unsigned PHASE_ROUND = 64'd8388608;

    localparam longint signed START_GAIN = 64'sd652032874;
    localparam longint signed UNIT_Q30 = 64'sd1073741824;
    localparam longint signed ROUND_HALF = 64'sd536870912;
    localparam longint signed WORD_MAX = 64'sd2147483647;
    localparam longint signed WORD_MIN = -64'sd2147483648;

    localparam longint signed ARC_STEP [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    class rotation_scoreboard;
        logic [15:0] snap_limit;
        rap_pkg::out_word_t rotated_due [$];
        int unsigned errors;

        function new();
            snap_limit = 16'd7;
            errors = 0;
        endfunction

        function int unsigned due_count();
            return rotated_due.size();
        endfunction

        // Rounds the Q30 product sum, adds the pivot back, then snaps and saturates.
        function logic [31:0] settle(longint signed acc, longint signed pivot, inout logic sat);
            longint signed v;
            longint signed mag;
            v = ((acc + ROUND_HALF) >>> 30) + pivot;
            mag = (v < 0) ? -v : v;
            if (mag <= longint'(snap_limit))
                return 32'd0;
            if (v > WORD_MAX)
            begin
                sat = 1'b1;
                return 32'h7FFF_FFFF;
            end
            if (v < WORD_MIN)
            begin
                sat = 1'b1;
                return 32'h8000_0000;
            end
            return 32'(v);
        endfunction

        function void note_point(rap_pkg::in_word_t w);
            longint unsigned turn;
            logic [31:0] phase;
            logic [31:0] resid;
            logic [1:0] quad;
            longint signed x;
            longint signed y;
            longint signed z;
            longint signed nx;
            longint signed cosv;
            longint signed sinv;
            longint signed dx;
            longint signed dy;
            logic sat;
            rap_pkg::out_word_t r;

            // A full turn of phase is 2^32, so any angle wraps into one turn.
            turn = longint'(w.angle);
            turn = turn * (w.angle_in_degrees ? DEGREE_SCALE : RADIAN_SCALE) + PHASE_ROUND;
            phase = 32'(turn >> 24);
            quad = 2'((phase + 32'h2000_0000) >> 30);
            resid = phase - {quad, 30'd0};
            z = longint'($signed(resid));

            x = START_GAIN;
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - ARC_STEP[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + ARC_STEP[i];
                end
                x = nx;
            end
            if (x > UNIT_Q30) x = UNIT_Q30;
            if (x < -UNIT_Q30) x = -UNIT_Q30;
            if (y > UNIT_Q30) y = UNIT_Q30;
            if (y < -UNIT_Q30) y = -UNIT_Q30;

            case (quad)
                2'd0:
                begin
                    cosv = x;
                    sinv = y;
                end
                2'd1:
                begin
                    cosv = -y;
                    sinv = x;
                end
                2'd2:
                begin
                    cosv = -x;
                    sinv = -y;
                end
                default:
                begin
                    cosv = y;
                    sinv = -x;
                end
            endcase

            dx = longint'(w.pos_x) - longint'(w.pivot_x);
            dy = longint'(w.pos_y) - longint'(w.pivot_y);
            sat = 1'b0;
            r.new_x = settle(dx * cosv - dy * sinv, longint'(w.pivot_x), sat);
            r.new_y = settle(dx * sinv + dy * cosv, longint'(w.pivot_y), sat);
            r.saturated = sat;
            rotated_due.push_back(r);
        endfunction

        function void check_rotated(rap_pkg::out_word_t got);
            rap_pkg::out_word_t want;
            if (rotated_due.size() == 0)
            begin
                $display("%0t: unexpected word: new_x %0d new_y %0d saturated %0b",
                         $time, got.new_x, got.new_y, got.saturated);
                errors++;
                return;
            end
            want = rotated_due.pop_front();
            if (got.new_x !== want.new_x)
            begin
                $display("%0t: new_x expected %0d actual %0d", $time, want.new_x, got.new_x);
                errors++;
            end
            if (got.new_y !== want.new_y)
            begin
                $display("%0t: new_y expected %0d actual %0d", $time, want.new_y, got.new_y);
                errors++;
            end
            if (got.saturated !== want.saturated)
            begin
                $display("%0t: saturated expected %0b actual %0b",
                         $time, want.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

endpackage

[sim/tb.sv]
`timescale 1ns / 1ps
// Testbench for the pivot rotator: directed and random words under varied idling and thresholds.
module tb;

    localparam int LATENCY = rotation_check_pkg::CORDIC_STEPS + 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 256;
    localparam int PHASES = 5;
    localparam logic [2:0] SNAP_ADDR = {rap_pkg::REG_ZERO_SNAP, 2'b00};
    localparam logic [2:0] UNMAPPED_ADDR = 3'd4;

    localparam logic signed [31:0] Q_ONE = 32'sd65536;
    localparam logic signed [31:0] QUARTER_DEG = 32'sd94371840;
    localparam logic signed [31:0] RIGHT_ANGLE_RAD = 32'sd1647099;
    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam int unsigned IDLE_PCT [PHASES] = '{0, 83, 7, 0, 83};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    rap_pkg::in_word_t item = '0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic busy;
    logic done;
    rap_pkg::out_word_t result;
    logic [31:0] prdata;
    logic pready;
    int unsigned cycles = 0;
    rotation_check_pkg::rotation_scoreboard sb;

    rotate_about_pivot_2d #(.CORDIC_STEPS(rotation_check_pkg::CORDIC_STEPS)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && paddr == SNAP_ADDR)
                sb.snap_limit = pwdata[15:0];
            if (start && !busy)
                sb.note_point(item);
            if (done)
                sb.check_rotated(result);
        end
    end

    function automatic logic signed [31:0] spread(int bits);
        return $signed($urandom) >>> (32 - bits);
    endfunction

    function automatic rap_pkg::in_word_t point_word(
        logic signed [31:0] px, logic signed [31:0] py,
        logic signed [31:0] cx, logic signed [31:0] cy,
        logic signed [31:0] ang, logic deg);
        rap_pkg::in_word_t w;
        w.pos_x = px;
        w.pos_y = py;
        w.pivot_x = cx;
        w.pivot_y = cy;
        w.angle = ang;
        w.angle_in_degrees = deg;
        return w;
    endfunction

    function automatic rap_pkg::in_word_t random_word();
        rap_pkg::in_word_t w;
        w = point_word($urandom, $urandom, $urandom, $urandom, $urandom,
                       1'($urandom_range(1)));
        case ($urandom_range(7))
            0, 1, 2:
            begin
                w.pos_x = spread(24);
                w.pos_y = spread(24);
                w.pivot_x = spread(20);
                w.pivot_y = spread(20);
            end
            3:
            begin
                w.pivot_x = '0;
                w.pivot_y = '0;
            end
            4:
            begin
                w.pivot_x = spread(18);
                w.pivot_y = spread(18);
                w.pos_x = w.pivot_x + spread(6);
                w.pos_y = w.pivot_y + spread(6);
            end
            5:
            begin
                w.pivot_x = '0;
                w.pivot_y = '0;
                w.pos_x = spread(17);
                w.pos_y = spread(17);
            end
            default: ;
        endcase
        case ($urandom_range(3))
            0: w.angle = spread(24);
            1:
            begin
                w.angle_in_degrees = 1'b1;
                w.angle = QUARTER_DEG * (int'($urandom_range(8)) - 4) + spread(3);
            end
            2: w.angle = spread(12);
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_word(rap_pkg::in_word_t w, int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Writes one address, then reads the threshold back; psel is left high for the caller.
    task automatic snap_access(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= SNAP_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[15:0] !== sb.snap_limit)
        begin
            $display("%0t: zero_snap_threshold expected %0d actual %0d",
                     $time, sb.snap_limit, prdata[15:0]);
            sb.errors++;
        end
    endtask

    task automatic drain();
        while (sb.due_count() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] next_snap;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_word(point_word(0, 0, 0, 0, 0, 1'b0), 0);
        send_word(point_word(Q_ONE, 0, 0, 0, QUARTER_DEG, 1'b1), 0);
        send_word(point_word(3 * Q_ONE, -5 * Q_ONE, Q_ONE, 2 * Q_ONE, 2 * QUARTER_DEG, 1'b1), 0);
        send_word(point_word(3 * Q_ONE, -5 * Q_ONE, Q_ONE, 2 * Q_ONE, -QUARTER_DEG, 1'b1), 0);
        send_word(point_word(3 * Q_ONE, -5 * Q_ONE, Q_ONE, 2 * Q_ONE, 3 * QUARTER_DEG, 1'b1), 0);
        send_word(point_word(3 * Q_ONE, -5 * Q_ONE, Q_ONE, 2 * Q_ONE, 4 * QUARTER_DEG, 1'b1), 0);
        send_word(point_word(Q_ONE, Q_ONE, 0, 0, RIGHT_ANGLE_RAD, 1'b0), 0);
        send_word(point_word(S_MAX, S_MAX, S_MIN, S_MIN, 2 * QUARTER_DEG, 1'b1), 0);
        send_word(point_word(S_MIN, S_MIN, S_MAX, S_MAX, 2 * QUARTER_DEG, 1'b1), 0);
        send_word(point_word(S_MAX, S_MIN, 0, 0, QUARTER_DEG, 1'b1), 0);
        send_word(point_word(S_MAX, S_MAX, 0, 0, 0, 1'b0), 0);
        send_word(point_word(5, -3, 5, -3, $urandom, 1'b0), 0);
        send_word(point_word(7 * Q_ONE, -2 * Q_ONE, 7 * Q_ONE, -2 * Q_ONE, $urandom, 1'b1), 0);
        send_word(point_word(6, 0, 0, 0, QUARTER_DEG, 1'b1), 0);
        send_word(point_word(8, 0, 0, 0, 0, 1'b0), 0);
        send_word(point_word(3 * Q_ONE, Q_ONE, -Q_ONE, 0, S_MAX, 1'b0), 0);
        send_word(point_word(3 * Q_ONE, Q_ONE, -Q_ONE, 0, S_MIN, 1'b0), 0);
        send_word(point_word(3 * Q_ONE, Q_ONE, -Q_ONE, 0, S_MAX, 1'b1), 0);
        send_word(point_word(3 * Q_ONE, Q_ONE, -Q_ONE, 0, S_MIN, 1'b1), 0);
        send_word(point_word(-1, -1, -1, -1, -1, 1'b1), 0);
        send_word(point_word(Q_ONE, -Q_ONE, 0, 0, 1, 1'b0), 0);
        send_word(point_word(Q_ONE, -Q_ONE, 0, 0, -1, 1'b1), 0);
        send_word(point_word(2 * Q_ONE, Q_ONE, 0, 0, QUARTER_DEG / 2, 1'b1), 0);
        send_word(point_word(2 * Q_ONE, Q_ONE, 0, 0, -QUARTER_DEG / 2, 1'b1), 0);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p != 0)
            begin
                start <= 1'b0;
                drain();
                case (p)
                    1: next_snap = 16'd0;
                    2: next_snap = 16'hFFFF;
                    3: next_snap = 16'($urandom_range(65535));
                    default: next_snap = 16'd7;
                endcase
                // Writes outside the threshold's address must leave it alone.
                if (p == 3)
                    snap_access(UNMAPPED_ADDR, $urandom);
                snap_access(SNAP_ADDR, {16'($urandom), next_snap});
                psel <= 1'b0;
                penable <= 1'b0;
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_word(random_word(), IDLE_PCT[p]);
        end

        start <= 1'b0;
        drain();
        if (sb.errors == 0 && sb.due_count() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
design/rap_pkg.sv
design/rap_phase.sv
design/rap_cordic.sv
design/rap_rotate.sv
design/rotate_about_pivot_2d.sv
sim/rotation_check_pkg.sv
sim/tb.sv
